>>> rtl/tkpp_pkg.sv
// ============================================================================
// tkpp_pkg: shared types and constants of the top-K spectral peak picker
// Field widths, reset values and the snapshot handoff used between units.
// ============================================================================
`default_nettype none

package tkpp_pkg;

    // Fixed field widths of the beat payloads.
    localparam int LEVEL_W      = 16;
    localparam int FRAME_W      = 16;
    localparam int PEAK_BIN_W   = 9;
    localparam int LOWEST_BIN_W = 9;

    // Defaults for the top-level parameters.
    localparam int TOP_K_DEFAULT = 5;
    localparam int BINS_DEFAULT  = 512;

    // Reset value of the lowest qualifying bin register.
    localparam logic [LOWEST_BIN_W-1:0] LOWEST_BIN_RESET = LOWEST_BIN_W'(10);

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [FRAME_W-1:0]        frame_t;

    // Handoff from the frame logic to the result buffer at a frame end.
    typedef struct packed {
        logic   load;
        frame_t frame;
    } snap_t;

endpackage

`default_nettype wire

>>> rtl/tkpp_keep.sv
// ============================================================================
// tkpp_keep: kept peak list of the current frame
// Holds up to TOP_K entries in arrival order and applies one offer per beat.
// ============================================================================
`default_nettype none

module tkpp_keep #(
    parameter int TOP_K = tkpp_pkg::TOP_K_DEFAULT,
    parameter int BINS  = tkpp_pkg::BINS_DEFAULT,
    localparam int BW   = $clog2(BINS),
    localparam int CW   = $clog2(TOP_K + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             offer_en,
    input  logic             qualify,
    input  logic             clear,
    input  tkpp_pkg::level_t level,
    input  logic [BW-1:0]    bin,
    output logic [CW-1:0]    snap_count,
    output logic [BW-1:0]    snap_bins [TOP_K],
    output tkpp_pkg::level_t snap_levels [TOP_K]
);
    import tkpp_pkg::*;

    logic [CW-1:0] count_reg;
    logic [BW-1:0] bins_reg [TOP_K];
    level_t        levels_reg [TOP_K];

    logic [CW-1:0] count_next;
    logic [BW-1:0] bins_next [TOP_K];
    level_t        levels_next [TOP_K];

    logic [TOP_K-1:0] weakest;
    logic [TOP_K-1:0] evict_from;
    logic             new_wins;
    logic             full;

    // Entry a is weaker than entry b: lower level, or equal level and higher bin.
    function automatic logic weaker(input level_t la, input logic [BW-1:0] ba,
                                    input level_t lb, input logic [BW-1:0] bb);
        logic r;
        if (la != lb)
        begin
            r = (la < lb);
        end
        else
        begin
            r = (ba > bb);
        end
        return r;
    endfunction

    // The weakest entry is the highest index among the entries of lowest rank:
    // it is no stronger than every earlier one and weaker than every later one.
    always_comb
    begin
        logic ok;
        for (int i = 0; i < TOP_K; i++)
        begin
            ok = 1'b1;
            for (int j = 0; j < TOP_K; j++)
            begin
                if (j < i)
                begin
                    if (weaker(levels_reg[j], bins_reg[j], levels_reg[i], bins_reg[i]))
                    begin
                        ok = 1'b0;
                    end
                end
                else if (j > i)
                begin
                    if (!weaker(levels_reg[i], bins_reg[i], levels_reg[j], bins_reg[j]))
                    begin
                        ok = 1'b0;
                    end
                end
            end
            weakest[i] = ok;
        end
    end

    always_comb
    begin
        logic acc;
        acc      = 1'b0;
        new_wins = 1'b0;
        for (int i = 0; i < TOP_K; i++)
        begin
            acc           = acc | weakest[i];
            evict_from[i] = acc;
            if (weakest[i] && weaker(levels_reg[i], bins_reg[i], level, bin))
            begin
                new_wins = 1'b1;
            end
        end
    end

    assign full = (count_reg == CW'(TOP_K));

    always_comb
    begin
        count_next  = count_reg;
        bins_next   = bins_reg;
        levels_next = levels_reg;
        if (qualify)
        begin
            if (!full)
            begin
                for (int i = 0; i < TOP_K; i++)
                begin
                    if (CW'(i) == count_reg)
                    begin
                        bins_next[i]   = bin;
                        levels_next[i] = level;
                    end
                end
                count_next = CW'(count_reg + 1'b1);
            end
            else if (new_wins)
            begin
                // Close the gap left by the evicted entry and append the newcomer.
                for (int i = 0; i < TOP_K - 1; i++)
                begin
                    if (evict_from[i])
                    begin
                        bins_next[i]   = bins_reg[i + 1];
                        levels_next[i] = levels_reg[i + 1];
                    end
                end
                bins_next[TOP_K-1]   = bin;
                levels_next[TOP_K-1] = level;
            end
        end
    end

    assign snap_count  = count_next;
    assign snap_bins   = bins_next;
    assign snap_levels = levels_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (offer_en)
        begin
            count_reg <= clear ? '0 : count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (offer_en)
        begin
            bins_reg   <= bins_next;
            levels_reg <= levels_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tkpp_emit.sv
// ============================================================================
// tkpp_emit: result buffer of a finished frame
// Takes the kept list at a frame end and shifts it out one peak per beat.
// ============================================================================
`default_nettype none

module tkpp_emit #(
    parameter int TOP_K = tkpp_pkg::TOP_K_DEFAULT,
    parameter int BINS  = tkpp_pkg::BINS_DEFAULT,
    localparam int BW   = $clog2(BINS),
    localparam int CW   = $clog2(TOP_K + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tkpp_pkg::snap_t                      snap,
    input  logic [CW-1:0]                        snap_count,
    input  logic [BW-1:0]                        snap_bins [TOP_K],
    input  tkpp_pkg::level_t                     snap_levels [TOP_K],
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output tkpp_pkg::frame_t                     frame_number,
    output logic [tkpp_pkg::PEAK_BIN_W-1:0]      peak_bin,
    output tkpp_pkg::level_t                     peak_level,
    output logic                                 last_peak
);
    import tkpp_pkg::*;

    logic [CW-1:0] count_reg;
    frame_t        frame_reg;
    logic [BW-1:0] bins_reg [TOP_K];
    level_t        levels_reg [TOP_K];
    logic          take;

    assign out_valid    = (count_reg != '0);
    assign take         = out_valid && !out_stall;
    assign frame_number = frame_reg;
    assign peak_bin     = PEAK_BIN_W'(bins_reg[0]);
    assign peak_level   = levels_reg[0];
    assign last_peak    = (count_reg == CW'(1));

    // A load only comes while the buffer is empty, so it never meets a take.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (snap.load)
        begin
            count_reg <= snap_count;
        end
        else if (take)
        begin
            count_reg <= CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap.load)
        begin
            frame_reg  <= snap.frame;
            bins_reg   <= snap_bins;
            levels_reg <= snap_levels;
        end
        else if (take)
        begin
            for (int i = 0; i < TOP_K - 1; i++)
            begin
                bins_reg[i]   <= bins_reg[i + 1];
                levels_reg[i] <= levels_reg[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/top_k_spectral_peak_picker_unit.sv
// ============================================================================
// top_k_spectral_peak_picker_unit: per-frame top-K spectral peak selection
// Keeps the TOP_K strongest qualifying bins of each frame and emits them in
// ascending bin order when the frame's last bin arrives.
// ============================================================================
//
//  Channel   | Direction | Handshake            | Payload
//  ----------+-----------+----------------------+---------------------------------
//  input     | in        | in_valid / in_stall  | level_db, frame_end
//  output    | out       | out_valid / out_stall| frame_number, peak_bin,
//            |           |                      | peak_level, last_peak
//  config    | in        | lowest_bin_we        | lowest_bin
//
//  An input beat is registered, then offered to the kept list from the input
//  register, so one bin is taken every cycle while the input does not stall.
//  A frame-end beat copies the final list into the result buffer, which
//  shifts out one peak per output beat, starting once the buffer is loaded.
//  The input stalls only when a frame-end beat waits in the input register
//  while the previous frame's peaks are still in the result buffer.
//  Reset (rst_n low, asynchronous) clears the counters, the kept count and
//  the result buffer, and sets lowest_bin to 10.
// ============================================================================
`default_nettype none

module top_k_spectral_peak_picker_unit #(
    parameter int TOP_K = tkpp_pkg::TOP_K_DEFAULT,
    parameter int BINS  = tkpp_pkg::BINS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                lowest_bin_we,
    input  logic [tkpp_pkg::LOWEST_BIN_W-1:0]   lowest_bin,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tkpp_pkg::level_t                    level_db,
    input  logic                                frame_end,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output tkpp_pkg::frame_t                    frame_number,
    output logic [tkpp_pkg::PEAK_BIN_W-1:0]     peak_bin,
    output tkpp_pkg::level_t                    peak_level,
    output logic                                last_peak
);
    import tkpp_pkg::*;

    localparam int BW   = $clog2(BINS);
    localparam int CW   = $clog2(TOP_K + 1);
    localparam int CMPW = (BW > LOWEST_BIN_W) ? BW : LOWEST_BIN_W;

    // Configuration register.
    logic [LOWEST_BIN_W-1:0] lowest_bin_reg;

    // Input register stage.
    logic   in_valid_reg;
    level_t in_level_reg;
    logic   in_end_reg;

    // Frame bookkeeping.
    logic [BW-1:0] bin_cnt_reg;
    logic [BW-1:0] bin_cnt_next;
    frame_t        frame_cnt_reg;
    frame_t        frame_cnt_next;

    logic          in_take;
    logic          proc;
    logic          qualify;
    snap_t         snap;
    logic [CW-1:0] snap_count;
    logic [BW-1:0] snap_bins [TOP_K];
    level_t        snap_levels [TOP_K];

    // The registered beat is worked on unless it ends a frame while the
    // result buffer still holds the previous frame's peaks.
    assign proc     = in_valid_reg && !(in_end_reg && out_valid);
    assign in_stall = in_valid_reg && !proc;
    assign in_take  = in_valid && !in_stall;

    assign qualify = (CMPW'(bin_cnt_reg) >= CMPW'(lowest_bin_reg));

    assign snap.load  = proc && in_end_reg;
    assign snap.frame = frame_cnt_reg;

    always_comb
    begin
        bin_cnt_next   = bin_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        if (proc)
        begin
            if (in_end_reg)
            begin
                bin_cnt_next   = '0;
                frame_cnt_next = FRAME_W'(frame_cnt_reg + 1'b1);
            end
            else if (bin_cnt_reg != BW'(BINS - 1))
            begin
                // The counter holds at the top bin for over-long frames.
                bin_cnt_next = BW'(bin_cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_bin_reg <= LOWEST_BIN_RESET;
            in_valid_reg   <= 1'b0;
            bin_cnt_reg    <= '0;
            frame_cnt_reg  <= '0;
        end
        else
        begin
            if (lowest_bin_we)
            begin
                lowest_bin_reg <= lowest_bin;
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            bin_cnt_reg   <= bin_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_level_reg <= level_db;
            in_end_reg   <= frame_end;
        end
    end

    tkpp_keep #(
        .TOP_K (TOP_K),
        .BINS  (BINS)
    ) u_keep (
        .clk         (clk),
        .rst_n       (rst_n),
        .offer_en    (proc),
        .qualify     (qualify),
        .clear       (in_end_reg),
        .level       (in_level_reg),
        .bin         (bin_cnt_reg),
        .snap_count  (snap_count),
        .snap_bins   (snap_bins),
        .snap_levels (snap_levels)
    );

    tkpp_emit #(
        .TOP_K (TOP_K),
        .BINS  (BINS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap         (snap),
        .snap_count   (snap_count),
        .snap_bins    (snap_bins),
        .snap_levels  (snap_levels),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .frame_number (frame_number),
        .peak_bin     (peak_bin),
        .peak_level   (peak_level),
        .last_peak    (last_peak)
    );

    // The input only backs up while a previous frame's peaks are pending.
    a_stall_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty result buffer");

    // A peak that is not the last one of its frame is followed by another.
    a_more_after_non_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_peak) |=> out_valid)
        else $error("result buffer ran dry before the last peak");

    // All peaks of one frame carry the same frame number.
    a_frame_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_peak) |=> frame_number == $past(frame_number))
        else $error("frame number changed within a frame's peaks");

endmodule

`default_nettype wire
